@@ sv/cltw_pkg.sv @@
// Shared types, command codes and expander byte helpers for the character-LCD
// terminal writer. Used by the top level, the expander encoder and the checker.
// Depends on nothing.
package cltw_pkg;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_PRINT = 2'd0;
  localparam func_t FUNC_CLEAR = 2'd1;
  localparam func_t FUNC_RAW   = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SCROLL_MODE = 2'd0;
  localparam cfg_idx_t CFG_LINE_LENGTH = 2'd1;
  localparam cfg_idx_t CFG_SHIFT_EN    = 2'd2;

  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SHIFT_LEFT = 8'h18;
  localparam logic [7:0] CMD_SET_ADDR   = 8'h80;

  localparam logic [7:0] BACKLIGHT_BIT = 8'h08;
  localparam logic [7:0] ENABLE_BIT    = 8'h04;
  localparam logic [7:0] NIBBLE_MASK   = 8'hF0;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;

  localparam logic [5:0] LINE_LENGTH_RESET = 6'd24;

  // DDRAM start address of each display row.
  localparam logic [3:0][7:0] ROW_BASE = {8'h54, 8'h14, 8'h40, 8'h00};

  // One controller write handed from the sequencer to the encoder.
  typedef struct packed {
    logic [7:0] value;
    logic       rs;
    logic       last;
  } wr_req_t;

  function automatic logic [7:0] expander_byte(input logic [3:0] nibble, input logic rs,
                                               input logic strobe);
    return ({nibble, 4'b0000} & NIBBLE_MASK) | BACKLIGHT_BIT |
           (strobe ? ENABLE_BIT : 8'h00) | {7'b0000000, rs};
  endfunction

endpackage

@@ sv/cltw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the terminal line store. Depends on nothing.
module cltw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/cltw_enc.sv @@
// Expander encoder and output register: turns one controller write into the
// four backpack bytes and holds them until taken. Depends on cltw_pkg.
module cltw_enc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  cltw_pkg::wr_req_t req,
  output logic              req_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_lcd_value,
  output logic              out_register_select,
  output logic [7:0]        out_high_strobe,
  output logic [7:0]        out_high_hold,
  output logic [7:0]        out_low_strobe,
  output logic [7:0]        out_low_hold,
  output logic              out_last
);

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] value_r;
  logic       rs_r;
  logic       last_r;

  assign req_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = req_valid || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      value_r <= req.value;
      rs_r    <= req.rs;
      last_r  <= req.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lcd_value       = value_r;
  assign out_register_select = rs_r;
  assign out_last            = last_r;
  assign out_high_strobe     = cltw_pkg::expander_byte(value_r[7:4], rs_r, 1'b1);
  assign out_high_hold       = cltw_pkg::expander_byte(value_r[7:4], rs_r, 1'b0);
  assign out_low_strobe      = cltw_pkg::expander_byte(value_r[3:0], rs_r, 1'b1);
  assign out_low_hold        = cltw_pkg::expander_byte(value_r[3:0], rs_r, 1'b0);

endmodule

@@ sv/char_lcd_terminal_writer_core.sv @@
// Character-LCD terminal writer: sequencer, line store and configuration.
// Depends on cltw_pkg, cltw_ram and cltw_enc.
//
// Usage. Items enter on the in_ channel (valid/ready): a function code and a
// character. Each item causes zero or more controller writes on the out_
// channel (valid/ready), each with the controller byte, its select flag, the
// four expander bytes and a last flag on the final write of the item. Items
// that cause no write (newline, carriage return, unused code, full line)
// leave no trace on the out_ channel.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata, and the
// user must write it only while the block is idle; the block does not enforce
// this. A write takes effect at once.
// Timing. in_ready is high only while the sequencer is idle. Every write goes
// through the shared encoder; line-store data during a scroll takes a RAM read
// and then an emit, set by the single registered read port of the line store.
// Reset (synchronous, rst_n low) restores the register defaults, empties the
// line store (all spaces), zeroes the column and arms a pending newline.
// When the receiver stalls, the output register holds its write and the
// sequencer waits; nothing is dropped.
module char_lcd_terminal_writer_core #(
  parameter int ROWS    = 2,
  parameter int COLUMNS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_character,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_lcd_value,
  output logic       out_register_select,
  output logic [7:0] out_high_strobe,
  output logic [7:0] out_high_hold,
  output logic [7:0] out_low_strobe,
  output logic [7:0] out_low_hold,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CB    = $clog2(COLUMNS);
  localparam int SW    = RB + RW + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_CURSOR = 7'b0000100,
    S_READ   = 7'b0001000,
    S_DATA   = 7'b0010000,
    S_CHAR   = 7'b0100000,
    S_SHIFT  = 7'b1000000
  } state_t;

  // The line store is a ring of rows: base_r is the physical row that shows
  // as the top row, so a scroll only moves the base and blanks one row.
  function automatic logic [RB-1:0] phys_of(input logic [RB-1:0] base,
                                            input logic [RW-1:0] row);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(row);
    if (sum >= SW'(ROWS)) begin
      sum = sum - SW'(ROWS);
    end
    return sum[RB-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [RB-1:0] prow,
                                            input logic [CB-1:0] col);
    return AW'(prow) * AW'(COLUMNS) + AW'(col);
  endfunction

  // Configuration registers.
  logic       scroll_mode_r, scroll_mode_nxt;
  logic [5:0] line_len_r, line_len_nxt;
  logic       shift_en_r, shift_en_nxt;

  // Terminal state.
  logic [5:0]       col_r, col_nxt;
  logic             pending_r, pending_nxt;
  logic [RB-1:0]    base_r, base_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;

  // Sequencer.
  state_t        state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CB-1:0] scol_r, scol_nxt;
  logic [7:0]    char_r, char_nxt;
  logic [AW-1:0] store_addr_r, store_addr_nxt;
  logic          store_en_r, store_en_nxt;
  logic          do_scroll_r, do_scroll_nxt;
  logic          do_char_r, do_char_nxt;
  logic          do_shift_r, do_shift_nxt;
  logic          vld_q_r, vld_q_nxt;

  // Per-item decisions.
  logic [5:0]    col_eff;
  logic [5:0]    col_inc;
  logic          fits_line;
  logic          fits_row;
  logic [RB-1:0] base_inc;
  state_t        after_clear;
  state_t        after_scroll;
  state_t        after_char;

  // Encoder and RAM hookup.
  logic              req_valid;
  logic              req_ready;
  cltw_pkg::wr_req_t req;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign col_eff   = pending_r ? 6'd0 : col_r;
  assign col_inc   = col_eff + 6'd1;
  assign fits_line = col_eff < line_len_r;
  assign fits_row  = col_eff < 6'(COLUMNS);
  assign base_inc  = (32'(base_r) + 32'd1 >= 32'(ROWS)) ? '0 : base_r + RB'(1);

  assign after_clear  = do_scroll_r ? S_CURSOR :
                        do_char_r   ? S_CHAR   :
                        do_shift_r  ? S_SHIFT  : S_IDLE;
  assign after_scroll = do_char_r  ? S_CHAR  : S_IDLE;
  assign after_char   = do_shift_r ? S_SHIFT : S_IDLE;

  assign ram_re    = (state_r == S_READ);
  assign ram_raddr = addr_of(phys_of(base_r, row_r), scol_r);
  assign ram_we    = (state_r == S_CHAR) && req_ready && store_en_r;

  always_comb begin
    scroll_mode_nxt = scroll_mode_r;
    line_len_nxt    = line_len_r;
    shift_en_nxt    = shift_en_r;
    col_nxt         = col_r;
    pending_nxt     = pending_r;
    base_nxt        = base_r;
    valid_nxt       = valid_r;
    state_nxt       = state_r;
    row_nxt         = row_r;
    scol_nxt        = scol_r;
    char_nxt        = char_r;
    store_addr_nxt  = store_addr_r;
    store_en_nxt    = store_en_r;
    do_scroll_nxt   = do_scroll_r;
    do_char_nxt     = do_char_r;
    do_shift_nxt    = do_shift_r;
    vld_q_nxt       = vld_q_r;
    req_valid       = 1'b0;
    req             = '0;

    if (cfg_wr_en) begin
      priority if (cfg_index == cltw_pkg::CFG_SCROLL_MODE) begin
        scroll_mode_nxt = cfg_wdata[0];
      end else if (cfg_index == cltw_pkg::CFG_LINE_LENGTH) begin
        line_len_nxt = cfg_wdata;
      end else if (cfg_index == cltw_pkg::CFG_SHIFT_EN) begin
        shift_en_nxt = cfg_wdata[0];
      end else begin
        shift_en_nxt = shift_en_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          do_scroll_nxt = 1'b0;
          do_char_nxt   = 1'b0;
          do_shift_nxt  = 1'b0;
          store_en_nxt  = 1'b0;
          char_nxt      = in_character;
          if (in_func == cltw_pkg::FUNC_CLEAR) begin
            col_nxt     = 6'd0;
            valid_nxt   = '0;
            pending_nxt = scroll_mode_r;
            state_nxt   = S_CLEAR;
          end else if (in_func == cltw_pkg::FUNC_RAW) begin
            state_nxt = S_CHAR;
          end else if (in_func == cltw_pkg::FUNC_PRINT) begin
            if (in_character == cltw_pkg::CHAR_NEWLINE) begin
              pending_nxt = 1'b1;
            end else if (in_character != cltw_pkg::CHAR_RETURN) begin
              pending_nxt = 1'b0;
              if (!scroll_mode_r) begin
                // Single line: a pending newline becomes a clear first.
                col_nxt      = fits_line ? col_inc : col_eff;
                do_char_nxt  = fits_line;
                do_shift_nxt = fits_line && shift_en_r && (col_inc > 6'(COLUMNS));
                state_nxt    = pending_r ? S_CLEAR : (fits_line ? S_CHAR : S_IDLE);
              end else begin
                // Scroll: on a pending newline, move the ring base up and blank
                // the row that becomes the bottom one, then rewrite every row.
                if (pending_r) begin
                  base_nxt = base_inc;
                  for (int r = 0; r < ROWS; r++) begin
                    for (int c = 0; c < COLUMNS; c++) begin
                      if (RB'(r) == base_r) begin
                        valid_nxt[r * COLUMNS + c] = 1'b0;
                      end
                    end
                  end
                end
                row_nxt        = '0;
                col_nxt        = fits_row ? col_inc : col_eff;
                do_scroll_nxt  = pending_r;
                do_char_nxt    = fits_row;
                store_en_nxt   = 1'b1;
                store_addr_nxt = addr_of(phys_of(base_nxt, RW'(ROWS - 1)),
                                         col_eff[CB-1:0]);
                state_nxt      = pending_r ? S_CURSOR : (fits_row ? S_CHAR : S_IDLE);
              end
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        req_valid = 1'b1;
        req       = '{value: cltw_pkg::CMD_CLEAR, rs: 1'b0,
                      last: !(do_scroll_r || do_char_r || do_shift_r)};
        if (req_ready) begin
          state_nxt = after_clear;
        end
      end
      S_CURSOR: begin
        req_valid = 1'b1;
        if (row_r == RW'(ROWS)) begin
          req = '{value: cltw_pkg::CMD_SET_ADDR | cltw_pkg::ROW_BASE[2'(ROWS - 1)],
                  rs: 1'b0, last: !do_char_r};
          if (req_ready) begin
            state_nxt = after_scroll;
          end
        end else begin
          req = '{value: cltw_pkg::CMD_SET_ADDR | cltw_pkg::ROW_BASE[2'(row_r)],
                  rs: 1'b0, last: 1'b0};
          if (req_ready) begin
            scol_nxt  = '0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        vld_q_nxt = valid_r[ram_raddr];
        state_nxt = S_DATA;
      end
      S_DATA: begin
        req_valid = 1'b1;
        req       = '{value: vld_q_r ? ram_rdata : cltw_pkg::CHAR_SPACE, rs: 1'b1,
                      last: 1'b0};
        if (req_ready) begin
          if (scol_r == CB'(COLUMNS - 1)) begin
            row_nxt   = row_r + RW'(1);
            state_nxt = S_CURSOR;
          end else begin
            scol_nxt  = scol_r + CB'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_CHAR: begin
        req_valid = 1'b1;
        req       = '{value: char_r, rs: 1'b1, last: !do_shift_r};
        if (req_ready) begin
          if (store_en_r) begin
            valid_nxt[store_addr_r] = 1'b1;
          end
          state_nxt = after_char;
        end
      end
      S_SHIFT: begin
        req_valid = 1'b1;
        req       = '{value: cltw_pkg::CMD_SHIFT_LEFT, rs: 1'b0, last: 1'b1};
        if (req_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_mode_r <= 1'b1;
      line_len_r    <= cltw_pkg::LINE_LENGTH_RESET;
      shift_en_r    <= 1'b1;
      col_r         <= 6'd0;
      pending_r     <= 1'b1;
      base_r        <= '0;
      valid_r       <= '0;
      state_r       <= S_IDLE;
      do_scroll_r   <= 1'b0;
      do_char_r     <= 1'b0;
      do_shift_r    <= 1'b0;
      store_en_r    <= 1'b0;
    end else begin
      scroll_mode_r <= scroll_mode_nxt;
      line_len_r    <= line_len_nxt;
      shift_en_r    <= shift_en_nxt;
      col_r         <= col_nxt;
      pending_r     <= pending_nxt;
      base_r        <= base_nxt;
      valid_r       <= valid_nxt;
      state_r       <= state_nxt;
      do_scroll_r   <= do_scroll_nxt;
      do_char_r     <= do_char_nxt;
      do_shift_r    <= do_shift_nxt;
      store_en_r    <= store_en_nxt;
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    scol_r       <= scol_nxt;
    char_r       <= char_nxt;
    store_addr_r <= store_addr_nxt;
    vld_q_r      <= vld_q_nxt;
  end

  cltw_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (store_addr_r),
    .wdata (char_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cltw_enc u_enc (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req_valid),
    .req                 (req),
    .req_ready           (req_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_lcd_value       (out_lcd_value),
    .out_register_select (out_register_select),
    .out_high_strobe     (out_high_strobe),
    .out_high_hold       (out_high_hold),
    .out_low_strobe      (out_low_strobe),
    .out_low_hold        (out_low_hold),
    .out_last            (out_last)
  );

endmodule

@@ sv/cltw_chk.sv @@
// Port-level checker for the terminal writer, bound to the top level.
// Depends on cltw_pkg and char_lcd_terminal_writer_core.
module cltw_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_lcd_value,
  input logic       out_register_select,
  input logic [7:0] out_high_strobe,
  input logic [7:0] out_high_hold,
  input logic [7:0] out_low_hold,
  input logic       out_last
);

  // The block is ready for an item right after reset.
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low after reset");

  // Expander bytes agree with the controller byte and the select flag.
  a_expander_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_high_hold == (out_high_strobe & ~cltw_pkg::ENABLE_BIT)) &&
                  ((out_high_hold & cltw_pkg::NIBBLE_MASK) ==
                   (out_lcd_value & cltw_pkg::NIBBLE_MASK)) &&
                  (out_low_hold[7:4] == out_lcd_value[3:0]) &&
                  (out_high_hold[3] == 1'b1) &&
                  (out_low_hold[0] == out_register_select))
    else $error("expander bytes do not match the controller byte");

  // Every command is a clear, a shift-left or a cursor address.
  a_command_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_register_select |->
      (out_lcd_value == cltw_pkg::CMD_CLEAR) ||
      (out_lcd_value == cltw_pkg::CMD_SHIFT_LEFT) || out_lcd_value[7])
    else $error("unexpected command byte");

  // A stalled write holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lcd_value) && $stable(out_last))
    else $error("stalled write changed");

endmodule

bind char_lcd_terminal_writer_core cltw_chk u_cltw_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_lcd_value       (out_lcd_value),
  .out_register_select (out_register_select),
  .out_high_strobe     (out_high_strobe),
  .out_high_hold       (out_high_hold),
  .out_low_hold        (out_low_hold),
  .out_last            (out_last)
);

@@ bench/tb_lcd_board_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the character-LCD terminal writer: predicts the controller writes
// that each accepted item causes and checks the writes that come out. Depends on cltw_pkg.
package tb_lcd_board_pkg;
  import cltw_pkg::*;

  localparam int ROWS    = 2;
  localparam int COLUMNS = 16;

  // Codes that the design package leaves unnamed: the spare function and register index.
  localparam func_t    FUNC_UNUSED = 2'd3;
  localparam cfg_idx_t CFG_SPARE   = 2'd3;

  typedef struct packed {
    logic [7:0] value;
    logic       rs;
    logic [7:0] high_strobe;
    logic [7:0] high_hold;
    logic [7:0] low_strobe;
    logic [7:0] low_hold;
    logic       last;
  } lcd_write_t;

  class lcd_write_board;
    lcd_write_t  want_q[$];
    int unsigned faults;
    bit          scroll_on;
    bit          shift_on;
    logic [5:0]  line_limit;
    logic [5:0]  column;
    bit          newline_armed;
    logic [7:0]  text_rows[ROWS][COLUMNS];

    function new();
      scroll_on     = 1'b1;
      shift_on      = 1'b1;
      line_limit    = LINE_LENGTH_RESET;
      column        = '0;
      newline_armed = 1'b1;
      faults        = 0;
      foreach (text_rows[r, k]) text_rows[r][k] = CHAR_SPACE;
    endfunction

    function void emit(logic [7:0] value, logic rs);
      lcd_write_t w;
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {value[7:4], 4'h0} | BACKLIGHT_BIT | {7'd0, rs};
      lo = {value[3:0], 4'h0} | BACKLIGHT_BIT | {7'd0, rs};
      w.value       = value;
      w.rs          = rs;
      w.high_strobe = hi | ENABLE_BIT;
      w.high_hold   = hi;
      w.low_strobe  = lo | ENABLE_BIT;
      w.low_hold    = lo;
      w.last        = 1'b0;
      want_q.push_back(w);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [5:0] data);
      case (idx)
        CFG_SCROLL_MODE: scroll_on = data[0];
        CFG_LINE_LENGTH: line_limit = data;
        CFG_SHIFT_EN:    shift_on = data[0];
        default: ;
      endcase
    endfunction

    function void note_item(func_t f, logic [7:0] c);
      int start;
      start = want_q.size();
      case (f)
        FUNC_CLEAR: begin
          emit(CMD_CLEAR, 1'b0);
          column = '0;
          foreach (text_rows[r, k]) text_rows[r][k] = CHAR_SPACE;
          newline_armed = scroll_on;
        end
        FUNC_RAW: emit(c, 1'b1);
        FUNC_PRINT: begin
          if (c == CHAR_NEWLINE) begin
            newline_armed = 1'b1;
          end else if (c != CHAR_RETURN) begin
            if (!scroll_on) begin
              if (newline_armed) begin
                emit(CMD_CLEAR, 1'b0);
                column        = '0;
                newline_armed = 1'b0;
              end
              if (column < line_limit) begin
                emit(c, 1'b1);
                column = column + 6'd1;
                if (shift_on && column > COLUMNS) emit(CMD_SHIFT_LEFT, 1'b0);
              end
            end else begin
              if (newline_armed) begin
                // Move every row up, blank the bottom one and redraw the whole screen.
                for (int r = 0; r + 1 < ROWS; r++)
                  for (int k = 0; k < COLUMNS; k++) text_rows[r][k] = text_rows[r + 1][k];
                for (int k = 0; k < COLUMNS; k++) text_rows[ROWS - 1][k] = CHAR_SPACE;
                for (int r = 0; r < ROWS; r++) begin
                  emit(CMD_SET_ADDR | ROW_BASE[r], 1'b0);
                  for (int k = 0; k < COLUMNS; k++) emit(text_rows[r][k], 1'b1);
                end
                emit(CMD_SET_ADDR | ROW_BASE[ROWS - 1], 1'b0);
                column        = '0;
                newline_armed = 1'b0;
              end
              if (column < COLUMNS) begin
                emit(c, 1'b1);
                text_rows[ROWS - 1][column] = c;
                column = column + 6'd1;
              end
            end
          end
        end
        default: ;
      endcase
      if (want_q.size() > start) want_q[want_q.size() - 1].last = 1'b1;
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        faults++;
        $display("%0t: %s expected %02h, got %02h", $time, field, want, got);
      end
    endfunction

    function void check_write(lcd_write_t got);
      lcd_write_t want;
      if (want_q.size() == 0) begin
        faults++;
        $display("%0t: write with nothing expected, expected none, got value %02h rs %0b",
                 $time, got.value, got.rs);
        return;
      end
      want = want_q.pop_front();
      compare("lcd_value", want.value, got.value);
      compare("register_select", {7'd0, want.rs}, {7'd0, got.rs});
      compare("high_strobe", want.high_strobe, got.high_strobe);
      compare("high_hold", want.high_hold, got.high_hold);
      compare("low_strobe", want.low_strobe, got.low_strobe);
      compare("low_hold", want.low_hold, got.low_hold);
      compare("last", {7'd0, want.last}, {7'd0, got.last});
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the regression for char_lcd_terminal_writer_core: drives items and register
// writes, checks every controller write. Depends on cltw_pkg, tb_lcd_board_pkg and the core.
module tb_top;
  import cltw_pkg::*;
  import tb_lcd_board_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_func = '0;
  logic [7:0] in_character = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_lcd_value;
  logic       out_register_select;
  logic [7:0] out_high_strobe;
  logic [7:0] out_high_hold;
  logic [7:0] out_low_strobe;
  logic [7:0] out_low_hold;
  logic       out_last;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_wdata = '0;

  // While set, the receiver never stalls and the sender adds no random gaps before items.
  bit             steady = 1'b0;
  int unsigned    random_items = 0;
  lcd_write_board board;

  char_lcd_terminal_writer_core #(
    .ROWS   (ROWS),
    .COLUMNS(COLUMNS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_character       (in_character),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_lcd_value      (out_lcd_value),
    .out_register_select(out_register_select),
    .out_high_strobe    (out_high_strobe),
    .out_high_hold      (out_high_hold),
    .out_low_strobe     (out_low_strobe),
    .out_low_hold       (out_low_hold),
    .out_last           (out_last),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls on about a third of the cycles, except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 34);
  end

  // Every write taken by the receiver is checked against the oldest predicted write.
  // Signals are read before this edge's updates land, so the sample matches what
  // the block saw at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_write({out_lcd_value, out_register_select, out_high_strobe,
                         out_high_hold, out_low_strobe, out_low_hold, out_last});
    end
  end

  // Offers one item and returns at the edge that accepts it. Valid is left high so a
  // following item can replace the payload in the same step without a dip.
  task automatic send_item(func_t f, logic [7:0] c);
    if (!steady && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_character <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(f, c);
  endtask

  // Drops valid and waits until every predicted write has come out. Items that cause
  // no write leave the sequencer idle, but a few more cycles pass anyway and then
  // the block has to show it is ready again.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Writes all three registers back to back while the block is idle. The single-bit
  // registers get random upper data bits, which the block has to ignore. With spare
  // set, the unused register index is written as well.
  task automatic load_config(bit mode, logic [5:0] length, bit shift, bit spare);
    cfg_idx_t   idx[4];
    logic [5:0] val[4];
    int         count;
    settle();
    idx    = '{CFG_SCROLL_MODE, CFG_LINE_LENGTH, CFG_SHIFT_EN, CFG_SPARE};
    val[0] = {5'($urandom), mode};
    val[1] = length;
    val[2] = {5'($urandom), shift};
    val[3] = 6'($urandom);
    count  = spare ? 4 : 3;
    cfg_wr_en <= 1'b1;
    for (int i = 0; i < count; i++) begin
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      board.write_reg(idx[i], val[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly printable text, sometimes any byte (which may itself be a newline or return).
  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(8'h20, 8'h7E));
    return 8'($urandom);
  endfunction

  // Lines of random text ended by newlines, with some noise mixed in: raw bytes,
  // clears, carriage returns, the unused function code and stray bytes. Single-line
  // lines can run past both the visible width and any length limit below 45;
  // scroll-mode lines sometimes run past the last column.
  task automatic run_text(bit mode, int items);
    int line_len;
    int sent;
    int pick;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: send_item(FUNC_RAW, 8'($urandom));
          1: send_item(FUNC_CLEAR, 8'($urandom));
          2: send_item(FUNC_PRINT, CHAR_RETURN);
          3: send_item(FUNC_UNUSED, 8'($urandom));
          default: send_item(FUNC_PRINT, 8'($urandom));
        endcase
        // Returns and the unused code are ignored by the block and are not counted.
        if (pick != 2 && pick != 3) sent++;
      end else begin
        line_len = mode ? $urandom_range(1, 20) : $urandom_range(1, 45);
        for (int k = 0; k < line_len && sent < items; k++) begin
          send_item(FUNC_PRINT, text_char());
          sent++;
        end
        if ($urandom_range(0, 9) < 8) begin
          send_item(FUNC_PRINT, CHAR_NEWLINE);
          sent++;
        end
        // Now and then the sender holds off until the block has drained completely.
        if ($urandom_range(0, 19) == 0) begin
          in_valid <= 1'b0;
          while (board.pending() != 0) @(posedge clk);
        end
      end
    end
    random_items += sent;
  endtask

  initial begin
    bit mode;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: scrolling terminal with a newline already armed, so the first
    // character redraws the blank screen before it is written.
    send_item(FUNC_PRINT, 8'h41);
    send_item(FUNC_PRINT, 8'hFF);
    send_item(FUNC_PRINT, 8'h00);
    send_item(FUNC_PRINT, CHAR_RETURN);
    send_item(FUNC_UNUSED, 8'h41);
    send_item(FUNC_RAW, 8'h00);
    send_item(FUNC_RAW, 8'hFF);
    send_item(FUNC_PRINT, CHAR_NEWLINE);
    // The scroll moves the first line up, so the redraw carries real text.
    send_item(FUNC_PRINT, 8'h42);
    send_item(FUNC_CLEAR, 8'h00);
    send_item(FUNC_PRINT, 8'h43);

    // Single line of one character: the column carried over from scroll mode already
    // fills the line, a newline arms a clear, the next character fits and the one after is refused.
    load_config(1'b0, 6'd1, 1'b0, 1'b1);
    send_item(FUNC_PRINT, 8'h78);
    send_item(FUNC_PRINT, CHAR_NEWLINE);
    send_item(FUNC_PRINT, 8'h79);
    send_item(FUNC_PRINT, 8'h7A);
    send_item(FUNC_CLEAR, 8'hFF);

    // A length of zero accepts no character; a pending clear still goes out.
    load_config(1'b0, 6'd0, 1'b1, 1'b0);
    send_item(FUNC_PRINT, 8'h71);
    send_item(FUNC_PRINT, CHAR_NEWLINE);
    send_item(FUNC_PRINT, 8'h72);

    // Random text. The first phases pin the extremes: the longest single line with
    // shifting, a scroll phase with no receiver stalls (entered with whatever
    // column the single line left behind), and the largest register length.
    load_config(1'b0, 6'd40, 1'b1, 1'b0);
    run_text(1'b0, 45);
    load_config(1'b1, 6'($urandom), 1'($urandom), 1'b0);
    steady <= 1'b1;
    run_text(1'b1, 40);
    settle();
    steady <= 1'b0;
    load_config(1'b0, 6'd63, 1'b0, 1'b0);
    run_text(1'b0, 40);
    while (random_items < 190) begin
      mode = 1'($urandom);
      load_config(mode,
                  ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 40)),
                  1'($urandom), 1'b0);
      run_text(mode, $urandom_range(20, 40));
    end

    // Drain, then leave room for a full scroll so that any stray write shows up.
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("char_lcd_terminal_writer_core regression: pass");
    end else begin
      $display("char_lcd_terminal_writer_core regression: fail");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every item a full scroll with the receiver
  // and the sender both stalling.
  initial begin
    #5_000_000;
    $display("char_lcd_terminal_writer_core regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
sv/cltw_pkg.sv
sv/cltw_ram.sv
sv/cltw_enc.sv
sv/char_lcd_terminal_writer_core.sv
sv/cltw_chk.sv
bench/tb_lcd_board_pkg.sv
bench/tb_top.sv
